// ===== sv/amd_pkg.sv =====
// ----------------------------------------------------------------------------
// amd_pkg
// Shared types, constants and the arctangent table for the affine matrix
// decomposition block.
// ----------------------------------------------------------------------------
package amd_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int ANGLE_W = 19;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DET,
        ST_SUMSQ,
        ST_SQRT,
        ST_DIV,
        ST_SSQ,
        ST_COS,
        ST_ATAN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_SCALE,
        C_ITER,
        C_OUT
    } t_cordic_state;

    // Rotation angle of CORDIC step i in Q2.30.
    function automatic logic signed [34:0] f_atan(input logic [4:0] i);
        logic signed [34:0] v;
        case (i)
            5'd0: v = 35'sd843314857;
            5'd1: v = 35'sd497837829;
            5'd2: v = 35'sd263043837;
            5'd3: v = 35'sd133525159;
            5'd4: v = 35'sd67021687;
            5'd5: v = 35'sd33543516;
            5'd6: v = 35'sd16775851;
            5'd7: v = 35'sd8388437;
            5'd8: v = 35'sd4194283;
            5'd9: v = 35'sd2097149;
            default: v = 35'sd1 <<< (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

// ===== sv/affine_matrix_decompose.sv =====
// ----------------------------------------------------------------------------
// affine_matrix_decompose
// Takes a transform matrix one column word at a time and, on the word marked
// last, returns translation, Euler XYZ rotation and signed scale. Column words
// that are not marked last are stored as they arrive. A last word starts a
// decomposition, during which the input is not ready: the columns are loaded,
// an 18-step determinant runs on the shared 33x33 multiplier, three column
// lengths are formed (squaring, then the 32-step square root unit), seven
// normalizing divisions run (17 quotient steps each), the clamped sine is
// squared and the square root gives cos(y), and up to three atan2 runs go on
// the CORDIC unit (prescale depending on operand size, 30 rotation steps, then
// handoff and rounding); the gimbal branch skips the x angle.
// A finished result waits in the output register while new columns are
// taken; gimbal_threshold is written through the configuration channel.
// ----------------------------------------------------------------------------
module affine_matrix_decompose (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_col_index,
    input  logic signed [31:0]  i_col_x,
    input  logic signed [31:0]  i_col_y,
    input  logic signed [31:0]  i_col_z,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_translation_x,
    output logic signed [31:0]  o_translation_y,
    output logic signed [31:0]  o_translation_z,
    output logic signed [18:0]  o_rotation_x,
    output logic signed [18:0]  o_rotation_y,
    output logic signed [18:0]  o_rotation_z,
    output logic signed [31:0]  o_scale_x,
    output logic signed [31:0]  o_scale_y,
    output logic signed [31:0]  o_scale_z,
    output logic                o_gimbal_lock,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [16:0]         i_cfg_data
);
    import amd_pkg::*;

    t_state r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_k, n_k;
    logic [2:0] r_job, n_job;

    logic [95:0] r_mem [4];
    logic [95:0] r_rda, r_rdb;
    logic [1:0]  ra, rb;
    logic [95:0] r_w0, r_w1, r_w2, r_w3;

    logic [16:0]         r_thr;
    logic signed [65:0]  r_prod;
    logic signed [32:0]  mul_a, mul_b;
    logic [63:0]         r_cross;
    logic signed [99:0]  r_det;
    logic [63:0]         r_sum;
    logic [30:0]         r_len [3];
    logic signed [18:0]  r_m [7];
    logic signed [17:0]  r_s;
    logic [16:0]         r_cy;
    logic signed [18:0]  r_rx, r_ry, r_rz;
    logic                r_out_valid;

    logic        in_acc;
    logic        neg;
    logic        gimbal;
    logic [1:0]  t_p, t_q;
    logic [95:0] col_k;
    logic signed [31:0] scl [3];

    logic        sq_start, sq_done;
    logic [63:0] sq_n;
    logic [31:0] sq_root;
    logic        dv_start, dv_done;
    logic signed [31:0] dv_num, dv_den;
    logic signed [18:0] dv_quot;
    logic [1:0]  dv_col, dv_row;
    logic        co_start, co_done;
    logic signed [18:0] co_y, co_x, co_angle;
    logic signed [18:0] s_neg;

    function automatic logic signed [31:0] f_row(input logic [95:0] w,
                                                 input logic [1:0] r);
        logic signed [31:0] v;
        case (r)
            2'd0:    v = w[31:0];
            2'd1:    v = w[63:32];
            default: v = w[95:64];
        endcase
        return v;
    endfunction

    function automatic logic signed [32:0] f_ext(input logic signed [31:0] v);
        return 33'(v);
    endfunction

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign neg         = r_det[99];
    assign gimbal      = !(r_cy > r_thr);

    always_comb begin
        case (r_k)
            2'd0:    col_k = r_w0;
            2'd1:    col_k = r_w1;
            default: col_k = r_w2;
        endcase
    end

    // Cross product row pairs for each determinant term.
    always_comb begin
        case (r_k)
            2'd0:    begin t_p = 2'd1; t_q = 2'd2; end
            2'd1:    begin t_p = 2'd2; t_q = 2'd0; end
            default: begin t_p = 2'd0; t_q = 2'd1; end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            scl[i] = neg ? -$signed({1'b0, r_len[i]}) : $signed({1'b0, r_len[i]});
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_k     <= '0;
            r_job   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_k     <= n_k;
            r_job   <= n_job;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_k     = r_k;
        n_job   = r_job;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_last) begin
                    n_state = ST_LOAD;
                    n_step  = '0;
                end
            end
            ST_LOAD: begin
                if (r_step == 3'd2) begin
                    n_state = ST_DET;
                    n_step  = '0;
                    n_k     = '0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_DET: begin
                if (r_step == 3'd5) begin
                    n_step = '0;
                    if (r_k == 2'd2) begin
                        n_state = ST_SUMSQ;
                        n_k     = '0;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_SUMSQ: begin
                if (r_step == 3'd3) begin
                    n_state = ST_SQRT;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_SQRT: begin
                if (r_step == 3'd0) begin
                    n_step = 3'd1;
                end else if (sq_done) begin
                    n_step = '0;
                    if (r_k == 2'd2) begin
                        n_state = ST_DIV;
                        n_job   = '0;
                    end else begin
                        n_state = ST_SUMSQ;
                        n_k     = r_k + 2'd1;
                    end
                end
            end
            ST_DIV: begin
                if (r_step == 3'd0) begin
                    n_step = 3'd1;
                end else if (dv_done) begin
                    n_step = '0;
                    if (r_job == 3'd6) begin
                        n_state = ST_SSQ;
                    end else begin
                        n_job = r_job + 3'd1;
                    end
                end
            end
            ST_SSQ: begin
                if (r_step == 3'd2) begin
                    n_state = ST_COS;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_COS: begin
                if (sq_done) begin
                    n_state = ST_ATAN;
                    n_step  = '0;
                    n_job   = '0;
                end
            end
            ST_ATAN: begin
                if (r_step == 3'd0) begin
                    // The x angle is not computed in the gimbal branch.
                    if (r_job == 3'd1 && gimbal) begin
                        n_job = 3'd2;
                    end else begin
                        n_step = 3'd1;
                    end
                end else if (co_done) begin
                    n_step = '0;
                    if (r_job == 3'd2) begin
                        n_state = ST_DONE;
                    end else begin
                        n_job = r_job + 3'd1;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Column store: one 96-bit word per column, two registered read ports.
    // ------------------------------------------------------------------
    assign ra = (r_step == 3'd0) ? 2'd0 : 2'd2;
    assign rb = (r_step == 3'd0) ? 2'd1 : 2'd3;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[i_col_index] <= {i_col_z, i_col_y, i_col_x};
        end
        r_rda <= r_mem[ra];
        r_rdb <= r_mem[rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand selection.
    // ------------------------------------------------------------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DET: begin
                case (r_step)
                    3'd0: begin
                        mul_a = f_ext(f_row(r_w1, t_p));
                        mul_b = f_ext(f_row(r_w2, t_q));
                    end
                    3'd1: begin
                        mul_a = f_ext(f_row(r_w1, t_q));
                        mul_b = f_ext(f_row(r_w2, t_p));
                    end
                    3'd3: begin
                        mul_a = f_ext(f_row(r_w0, r_k));
                        mul_b = $signed({1'b0, r_cross[31:0]});
                    end
                    3'd4: begin
                        mul_a = f_ext(f_row(r_w0, r_k));
                        mul_b = $signed({r_cross[63], r_cross[63:32]});
                    end
                    default: ;
                endcase
            end
            ST_SUMSQ: begin
                mul_a = f_ext(f_row(col_k, r_step[1:0]));
                mul_b = f_ext(f_row(col_k, r_step[1:0]));
            end
            ST_SSQ: begin
                mul_a = 33'(r_s);
                mul_b = 33'(r_s);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Unit operand selection.
    // ------------------------------------------------------------------
    assign sq_start = (r_state == ST_SQRT && r_step == 3'd0) ||
                      (r_state == ST_SSQ && r_step == 3'd2);
    assign sq_n     = (r_state == ST_SSQ) ? (64'h1_0000_0000 - 64'(r_prod[63:0])) : r_sum;

    always_comb begin
        case (r_job)
            3'd0:    begin dv_col = 2'd0; dv_row = 2'd0; end
            3'd1:    begin dv_col = 2'd0; dv_row = 2'd1; end
            3'd2:    begin dv_col = 2'd0; dv_row = 2'd2; end
            3'd3:    begin dv_col = 2'd1; dv_row = 2'd0; end
            3'd4:    begin dv_col = 2'd1; dv_row = 2'd1; end
            3'd5:    begin dv_col = 2'd1; dv_row = 2'd2; end
            default: begin dv_col = 2'd2; dv_row = 2'd2; end
        endcase
        case (dv_col)
            2'd0:    begin dv_num = f_row(r_w0, dv_row); dv_den = scl[0]; end
            2'd1:    begin dv_num = f_row(r_w1, dv_row); dv_den = scl[1]; end
            default: begin dv_num = f_row(r_w2, dv_row); dv_den = scl[2]; end
        endcase
    end

    assign dv_start = (r_state == ST_DIV && r_step == 3'd0);

    // Normalized entries: m[0] = m00, m[1] = m01, m[2] = m02, m[3] = m10,
    // m[4] = m11, m[5] = m12, m[6] = m22.
    always_comb begin
        co_y = '0;
        co_x = '0;
        case (r_job)
            3'd0: begin
                co_y = 19'(r_s);
                co_x = $signed({2'b00, r_cy});
            end
            3'd1: begin
                co_y = r_m[5];
                co_x = r_m[6];
            end
            default: begin
                if (gimbal) begin
                    co_y = -r_m[3];
                    co_x = r_m[4];
                end else begin
                    co_y = r_m[1];
                    co_x = r_m[0];
                end
            end
        endcase
    end

    assign co_start = (r_state == ST_ATAN && r_step == 3'd0) &&
                      !(r_job == 3'd1 && gimbal);
    assign s_neg    = -r_m[2];

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                if (r_step == 3'd1) begin
                    r_w0 <= r_rda;
                    r_w1 <= r_rdb;
                end else if (r_step == 3'd2) begin
                    r_w2 <= r_rda;
                    r_w3 <= r_rdb;
                end
                r_det <= '0;
            end
            ST_DET: begin
                case (r_step)
                    3'd1: r_cross <= r_prod[63:0];
                    3'd2: r_cross <= r_cross - r_prod[63:0];
                    3'd4: r_det   <= r_det + 100'(r_prod);
                    3'd5: r_det   <= r_det + $signed({{2{r_prod[65]}}, r_prod, 32'd0});
                    default: ;
                endcase
            end
            ST_SUMSQ: begin
                case (r_step)
                    3'd1:    r_sum <= r_prod[63:0];
                    3'd2,
                    3'd3:    r_sum <= r_sum + r_prod[63:0];
                    default: ;
                endcase
            end
            ST_SQRT: begin
                if (r_step == 3'd1 && sq_done) begin
                    r_len[r_k] <= sq_root[31] ? 31'h7FFF_FFFF : sq_root[30:0];
                end
            end
            ST_DIV: begin
                if (r_step == 3'd1 && dv_done) begin
                    r_m[r_job] <= dv_quot;
                end
            end
            ST_SSQ: begin
                if (r_step == 3'd0) begin
                    if (s_neg > 19'sd65536) begin
                        r_s <= 18'sd65536;
                    end else if (s_neg < -19'sd65536) begin
                        r_s <= -18'sd65536;
                    end else begin
                        r_s <= 18'(s_neg);
                    end
                end
            end
            ST_COS: begin
                if (sq_done) begin
                    r_cy <= sq_root[16:0];
                end
            end
            ST_ATAN: begin
                if (r_step == 3'd1 && co_done) begin
                    case (r_job)
                        3'd0:    r_ry <= co_angle;
                        3'd1:    r_rx <= co_angle;
                        default: r_rz <= co_angle;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
            o_translation_x <= r_w3[31:0];
            o_translation_y <= r_w3[63:32];
            o_translation_z <= r_w3[95:64];
            o_rotation_x    <= gimbal ? 19'sd0 : r_rx;
            o_rotation_y    <= r_ry;
            o_rotation_z    <= r_rz;
            o_scale_x       <= scl[0];
            o_scale_y       <= scl[1];
            o_scale_z       <= scl[2];
            o_gimbal_lock   <= gimbal;
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Shared iterative units.
    // ------------------------------------------------------------------
    amd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (sq_n),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    amd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    amd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (co_start),
        .i_y     (co_y),
        .i_x     (co_x),
        .o_done  (co_done),
        .o_angle (co_angle)
    );

endmodule

// ===== sv/amd_sqrt.sv =====
// ----------------------------------------------------------------------------
// amd_sqrt
// Iterative integer square root of a 64-bit word, one result bit per cycle.
// ----------------------------------------------------------------------------
module amd_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    output logic        o_done,
    output logic [31:0] o_root
);
    import amd_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_n;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_n   <= i_n;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

// ===== sv/amd_div.sv =====
// ----------------------------------------------------------------------------
// amd_div
// Restoring divider for column normalization: (num * 2^16) / den, truncated
// toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amd_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [31:0]   i_num,
    input  logic signed [31:0]   i_den,
    output logic                 o_done,
    output logic signed [18:0]   o_quot
);
    import amd_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic        r_zero;
    logic [47:0] r_rem;
    logic [47:0] r_ds;
    logic [16:0] r_q;
    logic [31:0] num_mag;
    logic [31:0] den_mag;

    assign num_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign den_mag = i_den[31] ? 32'(-i_den) : 32'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient never exceeds 2^16, so 17 bits of it are enough.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_neg  <= i_num[31] ^ i_den[31];
            r_zero <= (i_den == 32'sd0);
            r_rem  <= {num_mag, 16'd0};
            r_ds   <= {den_mag, 16'd0};
            r_q    <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_ds) begin
                r_rem <= r_rem - r_ds;
                r_q   <= {r_q[15:0], 1'b1};
            end else begin
                r_q   <= {r_q[15:0], 1'b0};
            end
            r_ds <= r_ds >> 1;
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_neg) begin
            o_quot = -$signed({2'b00, r_q});
        end else begin
            o_quot = $signed({2'b00, r_q});
        end
    end

    assign o_done = r_done;

endmodule

// ===== sv/amd_cordic.sv =====
// ----------------------------------------------------------------------------
// amd_cordic
// Vectoring CORDIC for atan2(y, x): quadrant fold, prescale by doubling,
// 30 rotation steps in Q2.30, then rounding and clamping to signed Q2.16.
// ----------------------------------------------------------------------------
module amd_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [18:0]   i_y,
    input  logic signed [18:0]   i_x,
    output logic                 o_done,
    output logic signed [18:0]   o_angle
);
    import amd_pkg::*;

    localparam logic signed [20:0] ANG_LIM = 21'sd205887;

    t_cordic_state      r_st;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic signed [47:0] r_x;
    logic signed [47:0] r_y;
    logic signed [34:0] r_z;
    logic signed [18:0] r_angle;

    logic signed [47:0] xs;
    logic signed [47:0] ys;
    logic [47:0]        y_mag;
    logic signed [47:0] dx;
    logic signed [47:0] dy;
    logic signed [34:0] z_rnd;
    logic signed [20:0] z_q16;

    assign xs    = 48'(i_x);
    assign ys    = 48'(i_y);
    assign y_mag = r_y[47] ? 48'(-r_y) : 48'(r_y);
    assign dx    = r_y >>> r_cnt;
    assign dy    = r_x >>> r_cnt;
    assign z_rnd = r_z + 35'sd8192;
    assign z_q16 = 21'(z_rnd >>> 14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= C_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                C_IDLE: begin
                    if (i_start) begin
                        r_st <= (i_x == 19'sd0 && i_y == 19'sd0) ? C_OUT : C_SCALE;
                    end
                end
                C_SCALE: begin
                    if (!(r_x[47:40] == 8'd0 && y_mag[47:40] == 8'd0)) begin
                        r_st <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                        r_st <= C_OUT;
                    end
                end
                C_OUT: begin
                    r_st   <= C_IDLE;
                    r_done <= 1'b1;
                end
                default: r_st <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            C_IDLE: begin
                r_cnt <= '0;
                if (i_x < 19'sd0) begin
                    // Fold the left half plane onto the right one.
                    r_x <= -xs;
                    r_y <= -ys;
                    r_z <= (i_y >= 19'sd0) ? PI_Q30 : -PI_Q30;
                end else begin
                    r_x <= xs;
                    r_y <= ys;
                    r_z <= '0;
                end
            end
            C_SCALE: begin
                if (r_x[47:40] == 8'd0 && y_mag[47:40] == 8'd0) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            C_ITER: begin
                r_cnt <= r_cnt + 5'd1;
                if (r_y > 48'sd0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + f_atan(r_cnt);
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - f_atan(r_cnt);
                end
            end
            C_OUT: begin
                if (z_q16 > ANG_LIM) begin
                    r_angle <= 19'(ANG_LIM);
                end else if (z_q16 < -ANG_LIM) begin
                    r_angle <= 19'(-ANG_LIM);
                end else begin
                    r_angle <= 19'(z_q16);
                end
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for affine_matrix_decompose. Column words are sent
// through a randomly idling driver. A matching predictor decomposes every
// matrix closed by a last word, and the results are compared field by field
// against the words taken from the output port.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import amd_pkg::*;

    typedef struct {
        logic [1:0]         idx;
        logic signed [31:0] x, y, z;
        logic               last;
    } t_column;

    typedef struct {
        logic signed [31:0] tr [3];
        logic signed [18:0] rot [3];
        logic signed [31:0] scl [3];
        logic               gl;
    } t_pose;

    localparam longint ONE = 64'sd65536;
    localparam longint PI_Q30_L = 64'sd3373259426;

    logic               i_clk, i_rst_n;
    logic               i_in_valid, o_in_ready;
    logic [1:0]         i_col_index;
    logic signed [31:0] i_col_x, i_col_y, i_col_z;
    logic               i_last;
    logic               o_out_valid, i_out_ready;
    logic signed [31:0] o_translation_x, o_translation_y, o_translation_z;
    logic signed [18:0] o_rotation_x, o_rotation_y, o_rotation_z;
    logic signed [31:0] o_scale_x, o_scale_y, o_scale_z;
    logic               o_gimbal_lock;
    logic               i_cfg_valid, o_cfg_ready;
    logic [16:0]        i_cfg_data;

    affine_matrix_decompose DUT (.*);

    t_column column_q[$];
    t_pose   expected_poses[$];
    longint  column_mem [12];
    logic [16:0] gimbal_limit;
    int      mismatches;
    int      words_sent;
    int      in_gap, out_gap;
    bit      in_burst, out_burst;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint rotation_step(input int i);
        longint steps [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                               33543516, 16775851, 8388437, 4194283, 2097149};
        return (i < 10) ? steps[i] : (64'sd1 <<< (30 - i));
    endfunction

    // Vectoring CORDIC; the result is the angle in Q2.30.
    function automatic longint cordic_angle(input longint yv, input longint xv);
        longint base, acc, dx, dy;
        base = 0;
        acc = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            base = (yv >= 0) ? PI_Q30_L : -PI_Q30_L;
            xv = -xv;
            yv = -yv;
        end
        while ((xv < 0 ? -xv : xv) < (64'sd1 <<< 40) && (yv < 0 ? -yv : yv) < (64'sd1 <<< 40)) begin
            xv = xv * 2;
            yv = yv * 2;
        end
        for (int i = 0; i < 30; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv = xv + dx; yv = yv - dy; acc = acc + rotation_step(i);
            end else begin
                xv = xv - dx; yv = yv + dy; acc = acc - rotation_step(i);
            end
        end
        return base + acc;
    endfunction

    function automatic logic signed [18:0] angle_word(input longint yv, input longint xv);
        longint r, lim;
        r = (cordic_angle(yv, xv) + 64'sd8192) >>> 14;
        lim = (PI_Q30_L + 64'sd8192) >>> 14;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[18:0];
    endfunction

    function automatic t_pose decompose_matrix();
        t_pose p;
        logic signed [129:0] cx, cy3, cz, d;
        longint unsigned sum, len, cosy;
        longint scl [3];
        longint m [3][3];
        longint s;
        bit neg;
        cx  = 130'(column_mem[4]) * column_mem[8] - 130'(column_mem[5]) * column_mem[7];
        cy3 = 130'(column_mem[5]) * column_mem[6] - 130'(column_mem[3]) * column_mem[8];
        cz  = 130'(column_mem[3]) * column_mem[7] - 130'(column_mem[4]) * column_mem[6];
        d = 130'(column_mem[0]) * cx + 130'(column_mem[1]) * cy3 + 130'(column_mem[2]) * cz;
        neg = d < 0;
        for (int k = 0; k < 3; k++) begin
            sum = 0;
            for (int r = 0; r < 3; r++)
                sum = sum + column_mem[k*3+r] * column_mem[k*3+r];
            len = int_sqrt(sum);
            if (len > 64'd2147483647) len = 64'd2147483647;
            scl[k] = neg ? -longint'(len) : longint'(len);
            for (int r = 0; r < 3; r++)
                m[k][r] = (scl[k] != 0) ? (column_mem[k*3+r] * ONE) / scl[k]
                                        : column_mem[k*3+r];
            p.scl[k] = scl[k][31:0];
            p.tr[k] = column_mem[9+k][31:0];
        end
        s = -m[0][2];
        if (s > ONE) s = ONE;
        if (s < -ONE) s = -ONE;
        cosy = int_sqrt(longint'(ONE * ONE) - s * s);
        p.rot[1] = angle_word(s, longint'(cosy));
        if (cosy > gimbal_limit) begin
            p.rot[0] = angle_word(m[1][2], m[2][2]);
            p.rot[2] = angle_word(m[0][1], m[0][0]);
            p.gl = 1'b0;
        end else begin
            p.rot[0] = '0;
            p.rot[2] = angle_word(-m[1][0], m[1][1]);
            p.gl = 1'b1;
        end
        return p;
    endfunction

    task automatic put_col(input int idx, input longint x, input longint y, input longint z,
                           input bit last);
        t_column c;
        c.idx = idx[1:0];
        c.x = x[31:0];
        c.y = y[31:0];
        c.z = z[31:0];
        c.last = last;
        column_q.push_back(c);
        words_sent++;
    endtask

    // Rotation Rz*Ry*Rx with per-column scale, columns sent in random order.
    task automatic put_pose(input real ax, input real ay, input real az, input real s0,
                            input real s1, input real s2);
        real sx, cxr, sy, cyr, sz, czr;
        longint c [4][3];
        int order [4];
        int j, t;
        sx = $sin(ax); cxr = $cos(ax);
        sy = $sin(ay); cyr = $cos(ay);
        sz = $sin(az); czr = $cos(az);
        c[0] = '{$rtoi(s0*cyr*czr*65536.0), $rtoi(s0*cyr*sz*65536.0), $rtoi(-s0*sy*65536.0)};
        c[1] = '{$rtoi(s1*(sx*sy*czr - cxr*sz)*65536.0),
                 $rtoi(s1*(sx*sy*sz + cxr*czr)*65536.0), $rtoi(s1*sx*cyr*65536.0)};
        c[2] = '{$rtoi(s2*(cxr*sy*czr + sx*sz)*65536.0),
                 $rtoi(s2*(cxr*sy*sz - sx*czr)*65536.0), $rtoi(s2*cxr*cyr*65536.0)};
        c[3] = '{longint'($signed($urandom)), longint'($signed($urandom)),
                 longint'($signed($urandom))};
        order = '{0, 1, 2, 3};
        for (int i = 3; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        for (int i = 0; i < 4; i++)
            put_col(order[i], c[order[i]][0], c[order[i]][1], c[order[i]][2], i == 3);
    endtask

    function automatic real rand_angle();
        return $urandom_range(0, 62831) / 10000.0 - 3.14159;
    endfunction

    function automatic real rand_scale();
        real v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(1, 1000) / 1000.0;
            1: v = $urandom_range(1, 30000) / 1000.0;
            2: v = $urandom_range(1, 32000);
            default: v = 1.0;
        endcase
        return ($urandom_range(0, 5) == 0) ? -v : v;
    endfunction

    function automatic longint rand_entry();
        case ($urandom_range(0, 2))
            0: return longint'($signed($urandom));
            1: return longint'($signed($urandom_range(0, 262143))) - 131072;
            default: return 0;
        endcase
    endfunction

    task automatic put_random_matrix();
        int kind, n;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            put_pose(rand_angle(), rand_angle(), rand_angle(),
                     rand_scale(), rand_scale(), rand_scale());
        end else if (kind == 5) begin
            // Gimbal region: y pinned at or very near a quarter turn.
            put_pose(rand_angle(), ($urandom_range(0, 1) ? 1.0 : -1.0) *
                     (1.5708 - $urandom_range(0, 20) / 1000.0), rand_angle(),
                     rand_scale(), rand_scale(), rand_scale());
        end else if (kind == 6) begin
            for (int k = 0; k < 4; k++)
                put_col(k, rand_entry(), rand_entry(), rand_entry(), k == 3);
        end else if (kind == 7) begin
            // Partial update of an already complete matrix.
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                put_col($urandom_range(0, 3), rand_entry(), rand_entry(), rand_entry(),
                        k == n - 1);
        end else begin
            // Columns that are stored but close no matrix.
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                put_col($urandom_range(0, 3), rand_entry(), rand_entry(), rand_entry(), 1'b0);
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (column_q.size() != 0 || i_in_valid || expected_poses.size() != 0);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_gimbal_limit(input logic [16:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        gimbal_limit = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Input driver.
    always @(posedge i_clk) begin
        bit next_valid;
        t_column c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                for (int r = 0; r < 3; r++)
                    column_mem[i_col_index*3+r] = (r == 0) ? i_col_x : (r == 1) ? i_col_y : i_col_z;
                if (i_last) expected_poses.push_back(decompose_matrix());
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (column_q.size() != 0) begin
                    c = column_q.pop_front();
                    i_col_index <= c.idx;
                    i_col_x <= c.x;
                    i_col_y <= c.y;
                    i_col_z <= c.z;
                    i_last <= c.last;
                    next_valid = 1'b1;
                    if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, 19);
                end
            end
            i_in_valid <= next_valid;
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_pose p;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_poses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("%0t: result word with none expected", $realtime);
                end else begin
                    p = expected_poses.pop_front();
                    check_field("translation_x", p.tr[0], o_translation_x);
                    check_field("translation_y", p.tr[1], o_translation_y);
                    check_field("translation_z", p.tr[2], o_translation_z);
                    check_field("rotation_x", p.rot[0], o_rotation_x);
                    check_field("rotation_y", p.rot[1], o_rotation_y);
                    check_field("rotation_z", p.rot[2], o_rotation_z);
                    check_field("scale_x", p.scl[0], o_scale_x);
                    check_field("scale_y", p.scl[1], o_scale_y);
                    check_field("scale_z", p.scl[2], o_scale_z);
                    check_field("gimbal_lock", p.gl, o_gimbal_lock);
                end
                if ($urandom_range(0, 9) == 0) out_burst = !out_burst;
                out_gap = out_burst ? 0 : $urandom_range(0, 19);
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [16:0] limits [6];
        mismatches = 0;
        words_sent = 0;
        in_gap = 0;
        out_gap = 0;
        in_burst = 0;
        out_burst = 0;
        gimbal_limit = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_col_index = '0;
        i_col_x = '0;
        i_col_y = '0;
        i_col_z = '0;
        i_last = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_gimbal_limit(17'd0);

        // Identity with the largest translation.
        put_col(0, ONE, 0, 0, 0);
        put_col(1, 0, ONE, 0, 0);
        put_col(2, 0, 0, ONE, 0);
        put_col(3, 2147483647, 2147483647, 2147483647, 1);
        // Largest entries everywhere: saturating length, smallest translation.
        put_col(0, 2147483647, 2147483647, 2147483647, 0);
        put_col(1, 2147483647, -2147483648, 2147483647, 0);
        put_col(2, -2147483648, 2147483647, 2147483647, 0);
        put_col(3, -2147483648, -2147483648, -2147483648, 1);
        // Exact quarter turn about y: the gimbal branch even at threshold zero.
        put_col(0, 0, 0, -ONE, 0);
        put_col(1, 0, ONE, 0, 0);
        put_col(2, ONE, 0, 0, 1);
        // Mirrored: negative determinant; with the negative scale, the same quarter turn.
        put_col(0, 0, 0, ONE, 1);
        // Zero-length columns: both arctangent arguments zero.
        put_col(1, 0, 0, 0, 0);
        put_col(2, 0, 0, 0, 1);
        // Smallest entries everywhere.
        put_col(0, -2147483648, -2147483648, -2147483648, 0);
        put_col(1, -2147483648, -2147483648, -2147483648, 0);
        put_col(2, -2147483648, -2147483648, -2147483648, 1);
        // Half turn about x.
        put_col(0, ONE, 0, 0, 0);
        put_col(1, 0, -ONE, 0, 0);
        put_col(2, 0, 0, -ONE, 1);

        limits = '{17'd0, 17'd65536, 17'd65535, 17'd1, 17'd0, 17'd0};
        limits[4] = $urandom_range(0, 65536);
        limits[5] = $urandom_range(0, 4000);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) write_gimbal_limit(limits[ph]);
            while (words_sent < 20 + (ph + 1) * 170) put_random_matrix();
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/amd_pkg.sv
sv/amd_sqrt.sv
sv/amd_div.sv
sv/amd_cordic.sv
sv/affine_matrix_decompose.sv
bench/tb.sv
